FILE: sv/ccrl_pkg.sv
// Shared types and constants for the charge current ramp limiter.
package ccrl_pkg;

    // Field widths.
    localparam int VoltW     = 10;
    localparam int CurrW     = 8;
    localparam int TickW     = 32;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 32;

    // Packed stream widths.
    localparam int InDataW  = 64;
    localparam int OutDataW = 8;
    localparam int OutUserW = 3;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] RegTargetVoltage = 2'd0;
    localparam logic [CfgIndexW-1:0] RegCvMargin      = 2'd1;
    localparam logic [CfgIndexW-1:0] RegRampStep      = 2'd2;
    localparam logic [CfgIndexW-1:0] RegRampInterval  = 2'd3;

    // Configuration reset values.
    localparam logic [VoltW-1:0] TargetVoltageRst = 10'd400;
    localparam logic [7:0]       CvMarginRst      = 8'd5;
    localparam logic [7:0]       RampStepRst      = 8'd2;
    localparam logic [TickW-1:0] RampIntervalRst  = 32'd100;

    // Charging phase reported with every result.
    typedef enum logic [1:0] {
        PHASE_CC       = 2'd0,
        PHASE_CV       = 2'd1,
        PHASE_OVERVOLT = 2'd2,
        PHASE_SHUTDOWN = 2'd3
    } phase_t;

endpackage

FILE: sv/charge_current_ramp_limiter.sv
// Charge current ramp limiter: top level with input stage, update logic and result stage.
//
// One update enters per clock cycle on the s_ side and its result leaves on the m_ side
// after passing through the input register and then the result register.
// Both stages advance whenever the result register is empty or being taken, so the
// block sustains one transfer per cycle. The request level and the last change time
// are updated in the same cycle the update leaves the input register, so the next
// update always sees them. Configuration writes take effect at once and are meant to
// happen while no update is in flight.
module charge_current_ramp_limiter
    import ccrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: now_ticks[31:0], measured_voltage[41:32], station_current[49:42],
    // battery_current_limit[57:50], zero fill[63:58]
    input  logic [InDataW-1:0]   s_tdata,
    // s_tuser: mode[0]
    input  logic                 s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: current_request[7:0]
    output logic [OutDataW-1:0]  m_tdata,
    // m_tuser: phase[1:0], changed[2]
    output logic [OutUserW-1:0]  m_tuser,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // Configuration registers.
    logic [VoltW-1:0] target_voltage_reg;
    logic [7:0]       cv_margin_reg;
    logic [7:0]       ramp_step_reg;
    logic [TickW-1:0] ramp_interval_reg;

    // Input stage.
    logic             in_valid_reg;
    logic             in_mode_reg;
    logic [TickW-1:0] in_now_reg;
    logic [VoltW-1:0] in_volt_reg;
    logic [CurrW-1:0] in_station_reg;
    logic [CurrW-1:0] in_battery_reg;

    // Controller state.
    logic [CurrW-1:0] level_reg;
    logic [CurrW-1:0] level_next;
    logic [TickW-1:0] last_change_reg;

    // Result stage.
    logic             out_valid_reg;
    logic [CurrW-1:0] out_request_reg;
    phase_t           out_phase_reg;
    logic             out_changed_reg;

    // Update logic.
    logic             advance;
    logic             in_accept;
    logic             work;
    phase_t           phase;
    logic [CurrW-1:0] ceiling;
    logic [CurrW-1:0] goal;
    logic             down_only;
    logic             do_slew;
    logic [TickW-1:0] elapsed;
    logic             interval_ok;
    logic [CurrW-1:0] slew_level;
    logic             changed;
    logic [VoltW:0]   window_sum;

    // Both stages move whenever the result register is free or being taken.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign work      = in_valid_reg && advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_voltage_reg <= TargetVoltageRst;
            cv_margin_reg      <= CvMarginRst;
            ramp_step_reg      <= RampStepRst;
            ramp_interval_reg  <= RampIntervalRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegTargetVoltage: target_voltage_reg <= cfg_data[VoltW-1:0];
                RegCvMargin:      cv_margin_reg      <= cfg_data[7:0];
                RegRampStep:      ramp_step_reg      <= cfg_data[7:0];
                RegRampInterval:  ramp_interval_reg  <= cfg_data[TickW-1:0];
                default:          ;
            endcase
        end
    end

    // Phase selection and the goal of the slew.
    always_comb
    begin
        ceiling    = (in_station_reg < in_battery_reg) ? in_station_reg : in_battery_reg;
        window_sum = {1'b0, in_volt_reg} + {3'b000, cv_margin_reg};
        goal       = ceiling;
        down_only  = 1'b0;
        do_slew    = 1'b1;
        if (in_mode_reg)
        begin
            phase     = PHASE_SHUTDOWN;
            goal      = '0;
            down_only = 1'b1;
        end
        else if (window_sum < {1'b0, target_voltage_reg})
        begin
            phase = PHASE_CC;
        end
        else if (in_volt_reg < target_voltage_reg)
        begin
            phase     = PHASE_CV;
            down_only = 1'b1;
        end
        else
        begin
            phase   = PHASE_OVERVOLT;
            do_slew = 1'b0;
        end
    end

    // Slew by at most one step once the ramp interval has passed.
    always_comb
    begin
        elapsed     = in_now_reg - last_change_reg;
        interval_ok = elapsed >= ramp_interval_reg;
        slew_level  = level_reg;
        if (level_reg < goal)
        begin
            if (!down_only)
            begin
                slew_level = ((goal - level_reg) > ramp_step_reg) ?
                             level_reg + ramp_step_reg : goal;
            end
        end
        else if (level_reg > goal)
        begin
            slew_level = ((level_reg - goal) > ramp_step_reg) ?
                         level_reg - ramp_step_reg : goal;
        end
    end

    // New request level; over voltage steps down by one and stops at zero.
    always_comb
    begin
        if (do_slew)
        begin
            level_next = interval_ok ? slew_level : level_reg;
        end
        else
        begin
            level_next = (level_reg != '0) ? level_reg - 8'd1 : level_reg;
        end
        changed = level_next != level_reg;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_mode_reg    <= s_tuser;
            in_now_reg     <= s_tdata[31:0];
            in_volt_reg    <= s_tdata[41:32];
            in_station_reg <= s_tdata[49:42];
            in_battery_reg <= s_tdata[57:50];
        end
    end

    // Controller state; the time is recorded only when a slew moves the level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            last_change_reg <= '0;
        end
        else if (work)
        begin
            level_reg <= level_next;
            if (do_slew && changed)
            begin
                last_change_reg <= in_now_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_request_reg <= level_next;
            out_phase_reg   <= phase;
            out_changed_reg <= changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_request_reg;
    assign m_tuser  = {out_changed_reg, out_phase_reg};

endmodule

FILE: sv/ccrl_checker.sv
// Port-level checker for the charge current ramp limiter, bound to the top level.
module ccrl_checker
    import ccrl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OutDataW-1:0]  m_tdata,
    input logic [OutUserW-1:0]  m_tuser
);

    // Request level carried by the last result transfer; zero after reset.
    logic [OutDataW-1:0] last_req_reg;
    logic                out_xfer;

    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_req_reg <= '0;
        end
        else if (out_xfer)
        begin
            last_req_reg <= m_tdata;
        end
    end

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The changed flag agrees with the sequence of request levels.
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (m_tuser[2] == (m_tdata != last_req_reg)))
        else $error("changed flag does not match the request sequence");

    // Over voltage, when it changes the request, lowers it by exactly one.
    a_overvolt_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_tuser[1:0] == PHASE_OVERVOLT && m_tuser[2]
            |-> m_tdata == last_req_reg - 8'd1)
        else $error("over voltage step is not one");

    // Shutdown and constant voltage never raise the request.
    a_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && (m_tuser[1:0] == PHASE_SHUTDOWN || m_tuser[1:0] == PHASE_CV)
            |-> m_tdata <= last_req_reg)
        else $error("request rose in a down-only phase");

endmodule

bind charge_current_ramp_limiter ccrl_checker u_ccrl_checker (.*);
